FILE: rtl/octave_band_spectral_cross_synthesis_assert.svh
// Assertion macros shared by the checker of the octave band cross synthesis block
`ifndef OCTAVE_BAND_SPECTRAL_CROSS_SYNTHESIS_ASSERT_SVH
`define OCTAVE_BAND_SPECTRAL_CROSS_SYNTHESIS_ASSERT_SVH

// ante in one cycle implies cons in the next, outside reset
`define OBSCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("obscs: next-cycle check failed");

// cons holds on the cycle after reset was high
`define OBSCS_ASSERT_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("obscs: post-reset check failed");

`endif

FILE: rtl/obscs_pkg.sv
// Shared constants, types and functions of the octave band cross synthesis block
package obscs_pkg;

   localparam int FRAME_BINS   = 512;
   localparam int SAMPLE_WIDTH = 16;
   localparam int MAX_BANDS    = 10;

   localparam int BIN_W      = $clog2(FRAME_BINS);
   localparam int BAND_W     = $clog2(MAX_BANDS);
   localparam int ENERGY_W   = 48;
   localparam int GAIN_W     = 24;
   localparam int GAIN_FRAC  = GAIN_W / 2;
   localparam int SQ_W       = 2 * SAMPLE_WIDTH;
   localparam int MUL_W      = SAMPLE_WIDTH + GAIN_W;
   localparam int NUM_W      = ENERGY_W + GAIN_W;
   localparam int DEN_W      = ENERGY_W + 1;
   localparam int RAD_W      = 2 * GAIN_W;
   localparam int SREM_W     = GAIN_W + 1;
   localparam int CNT_W      = $clog2(NUM_W);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

   localparam int SIB_W      = 10;
   localparam int CUT_W      = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SIB_PASS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIB_BIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_CUT  = 2'd2;

   localparam logic [SIB_W-1:0] SIB_BIN_RESET = 10'd93;

   // work steps of the back end
   localparam logic [CNT_W-1:0] STEP_IM_MUL = CNT_W'(4);
   localparam logic [CNT_W-1:0] STEP_RE_FIN = CNT_W'(5);
   localparam logic [CNT_W-1:0] STEP_LAST   = CNT_W'(6);

   typedef struct packed {
      logic             pass;
      logic [SIB_W-1:0] sib;
      logic [CUT_W-1:0] cut;
   } cfg_type;

   typedef struct packed {
      logic              hit;
      logic [BAND_W-1:0] idx;
   } band_type;

   // one classified request in the queue
   typedef struct packed {
      logic [BIN_W-1:0]               idx;
      logic signed [SAMPLE_WIDTH-1:0] sre;
      logic signed [SAMPLE_WIDTH-1:0] sim;
      logic signed [SAMPLE_WIDTH-1:0] fre;
      logic signed [SAMPLE_WIDTH-1:0] fim;
      logic                           store_filter;
      band_type                       cur;
      logic                           zero_out;
      band_type                       prev;
      logic                           last;
   } entry_type;

   typedef enum logic [2:0] {
      B_IDLE, B_WORK, B_EMIT, B_GINIT, B_DIV, B_ROOTI, B_ROOT, B_GNEXT
   } back_state_type;

   // top edge: sibilance bin if passing and within the frame, else frame length
   function automatic logic [BIN_W:0] top_of(cfg_type c);
      logic [BIN_W:0] t;
      t = (BIN_W+1)'(FRAME_BINS);
      if (c.pass && (int'(c.sib) < FRAME_BINS)) t = (BIN_W+1)'(c.sib);
      return t;
   endfunction

   // octave band of a bin, halving down from the top edge
   function automatic band_type band_of(logic [BIN_W-1:0] i, cfg_type c);
      logic [BIN_W:0] high;
      logic [BIN_W:0] low;
      logic           done;
      band_type       b;
      b    = '0;
      done = 1'b0;
      high = top_of(c);
      for (int k = 0; k < MAX_BANDS; k++) begin
         low = high >> 1;
         if (!done) begin
            if (low <= (BIN_W+1)'(c.cut)) begin
               done = 1'b1;
            end else if (({1'b0, i} >= low) && ({1'b0, i} < high)) begin
               b.hit = 1'b1;
               b.idx = BAND_W'(k);
               done  = 1'b1;
            end
         end
         high = low;
      end
      return b;
   endfunction

   // round magnitude product to nearest, apply sign, saturate
   function automatic logic signed [SAMPLE_WIDTH-1:0] scale_fin(logic [MUL_W-1:0] mag,
                                                                logic neg);
      logic [MUL_W-1:0]        r;
      logic [SAMPLE_WIDTH-1:0] smax;
      logic [SAMPLE_WIDTH-1:0] res;
      smax = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      r    = (mag + (MUL_W'(1) << (GAIN_FRAC-1))) >> GAIN_FRAC;
      if (!neg) begin
         res = (r > MUL_W'(smax)) ? smax : r[SAMPLE_WIDTH-1:0];
      end else begin
         res = (r > MUL_W'(smax) + MUL_W'(1)) ? ~smax : (~r[SAMPLE_WIDTH-1:0] + 1'b1);
      end
      return signed'(res);
   endfunction

endpackage

FILE: rtl/obscs_front.sv
// Front end: register file, bin counter, frame config latching and band classification
module obscs_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [obscs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [obscs_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [obscs_pkg::SAMPLE_WIDTH-1:0] req_source_re,
   input  logic signed [obscs_pkg::SAMPLE_WIDTH-1:0] req_source_im,
   input  logic signed [obscs_pkg::SAMPLE_WIDTH-1:0] req_filter_re,
   input  logic signed [obscs_pkg::SAMPLE_WIDTH-1:0] req_filter_im,
   input  logic                                   q_full,
   output logic                                   q_push,
   output obscs_pkg::entry_type                   q_entry
);

   obscs_pkg::cfg_type regs_ff, regs_in;
   obscs_pkg::cfg_type cur_ff, cur_in;
   obscs_pkg::cfg_type prev_ff, prev_in;
   logic [obscs_pkg::BIN_W-1:0] idx_ff, idx_in;
   logic                        have_prev_ff, have_prev_in;
   obscs_pkg::cfg_type          cfg_now;
   logic                        last_bin;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;
   assign last_bin  = (idx_ff == obscs_pkg::BIN_W'(obscs_pkg::FRAME_BINS - 1));
   // registers are latched at bin 0 of each frame
   assign cfg_now   = (idx_ff == '0) ? regs_ff : cur_ff;

   // register writes
   always_comb begin
      regs_in = regs_ff;
      if (csr_we) begin
         unique case (csr_index)
            obscs_pkg::REG_SIB_PASS: regs_in.pass = csr_wdata[0];
            obscs_pkg::REG_SIB_BIN:  regs_in.sib  = csr_wdata[obscs_pkg::SIB_W-1:0];
            obscs_pkg::REG_LOW_CUT:  regs_in.cut  = csr_wdata[obscs_pkg::CUT_W-1:0];
            default: ;
         endcase
      end
   end

   // classify the request
   always_comb begin
      q_entry.idx          = idx_ff;
      q_entry.sre          = req_source_re;
      q_entry.sim          = req_source_im;
      q_entry.fre          = req_filter_re;
      q_entry.fim          = req_filter_im;
      q_entry.store_filter = cfg_now.pass && ({1'b0, idx_ff} >= obscs_pkg::top_of(cfg_now));
      q_entry.cur          = obscs_pkg::band_of(idx_ff, cfg_now);
      q_entry.zero_out     = !have_prev_ff ||
                             (obscs_pkg::CUT_W'(idx_ff) <= prev_ff.cut);
      q_entry.prev         = obscs_pkg::band_of(idx_ff, prev_ff);
      q_entry.last         = last_bin;
   end

   // bin counter and frame bookkeeping
   always_comb begin
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      if (q_push) begin
         cur_in = cfg_now;
         if (last_bin) begin
            idx_in       = '0;
            prev_in      = cfg_now;
            have_prev_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff      <= '{pass: 1'b0, sib: obscs_pkg::SIB_BIN_RESET, cut: '0};
         cur_ff       <= '{pass: 1'b0, sib: obscs_pkg::SIB_BIN_RESET, cut: '0};
         prev_ff      <= '{pass: 1'b0, sib: obscs_pkg::SIB_BIN_RESET, cut: '0};
         idx_ff       <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         regs_ff      <= regs_in;
         cur_ff       <= cur_in;
         prev_ff      <= prev_in;
         idx_ff       <= idx_in;
         have_prev_ff <= have_prev_in;
      end
   end

endmodule

FILE: rtl/obscs_fifo.sv
// Short request queue between front and back end
module obscs_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  obscs_pkg::entry_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 valid,
   output obscs_pkg::entry_type pop_data
);

   obscs_pkg::entry_type          slot_ff [obscs_pkg::QUEUE_DEPTH];
   logic [obscs_pkg::QPTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [obscs_pkg::QPTR_W:0]    cnt_ff, cnt_in;

   assign full     = (cnt_ff == (obscs_pkg::QPTR_W+1)'(obscs_pkg::QUEUE_DEPTH));
   assign valid    = (cnt_ff != '0);
   assign pop_data = slot_ff[rd_ff];

   // pointer update
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (obscs_pkg::QPTR_W+1)'(push) - (obscs_pkg::QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end

endmodule

FILE: rtl/obscs_back.sv
// Back end: bin store, band energies, output scaling and frame-end gain unit
module obscs_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    q_valid,
   input  obscs_pkg::entry_type                    q_entry,
   output logic                                    q_pop,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [obscs_pkg::SAMPLE_WIDTH-1:0] rsp_out_re,
   output logic signed [obscs_pkg::SAMPLE_WIDTH-1:0] rsp_out_im,
   output logic                                    rsp_frame_end
);

   localparam int SW = obscs_pkg::SAMPLE_WIDTH;

   obscs_pkg::back_state_type state_ff, state_in;

   logic [obscs_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [obscs_pkg::BAND_W-1:0]    band_ff, band_in;
   obscs_pkg::entry_type            ent_ff;
   logic [2*SW-1:0]                 store_mem [obscs_pkg::FRAME_BINS];
   logic [2*SW-1:0]                 rd_ff;
   logic signed [SW-1:0]            old_re, old_im;
   logic [obscs_pkg::ENERGY_W-1:0]  fe_ff [obscs_pkg::MAX_BANDS];
   logic [obscs_pkg::ENERGY_W-1:0]  se_ff [obscs_pkg::MAX_BANDS];
   logic [obscs_pkg::GAIN_W-1:0]    gain_ff [obscs_pkg::MAX_BANDS];
   logic [obscs_pkg::GAIN_W-1:0]    g_ff;
   logic [obscs_pkg::SQ_W-1:0]      sq_ff;
   logic signed [obscs_pkg::SQ_W-1:0] sq_in;
   logic signed [SW-1:0]            sq_op;
   logic [obscs_pkg::MUL_W-1:0]     mul_ff;
   logic [SW-1:0]                   mul_op;
   logic signed [SW-1:0]            res_re_ff;
   logic signed [SW-1:0]            res_re_in;
   logic [obscs_pkg::BAND_W-1:0]    e_idx;
   logic [obscs_pkg::ENERGY_W-1:0]  fe_rd, se_rd;
   logic                            load_out;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]            out_re_ff, out_im_ff, out_re_in, out_im_in;
   logic                            frame_end_ff;

   // divider and square root
   logic [obscs_pkg::DEN_W-1:0]     den_ff;
   logic [obscs_pkg::NUM_W-1:0]     num_ff;
   logic [obscs_pkg::DEN_W-1:0]     rem_ff;
   logic [obscs_pkg::DEN_W:0]       rem_sh;
   logic                            qbit;
   logic [obscs_pkg::RAD_W-1:0]     rad_ff;
   logic [obscs_pkg::GAIN_W-1:0]    root_ff, root_in;
   logic [obscs_pkg::SREM_W-1:0]    srem_ff;
   logic [obscs_pkg::SREM_W+1:0]    srem_sh, trial;
   logic                            take;
   logic [obscs_pkg::GAIN_W-1:0]    gnew_ff;

   assign old_re = signed'(rd_ff[2*SW-1:SW]);
   assign old_im = signed'(rd_ff[SW-1:0]);
   assign e_idx  = (state_ff == obscs_pkg::B_WORK) ? ent_ff.cur.idx : band_ff;
   assign fe_rd  = fe_ff[e_idx];
   assign se_rd  = se_ff[e_idx];

   // square operand per step: filter re, filter im, source re, source im
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    sq_op = ent_ff.fre;
         2'd1:    sq_op = ent_ff.fim;
         2'd2:    sq_op = ent_ff.sre;
         default: sq_op = ent_ff.sim;
      endcase
   end
   assign sq_in = sq_op * sq_op;

   // magnitude operand for the gain multiply
   always_comb begin
      if (cnt_ff == obscs_pkg::STEP_IM_MUL) begin
         mul_op = old_re[SW-1] ? SW'(-old_re) : SW'(old_re);
      end else begin
         mul_op = old_im[SW-1] ? SW'(-old_im) : SW'(old_im);
      end
   end
   assign res_re_in = obscs_pkg::scale_fin(mul_ff, old_re[SW-1]);

   // restoring divide and root steps
   assign rem_sh  = {rem_ff, num_ff[obscs_pkg::NUM_W-1]};
   assign qbit    = (rem_sh >= {1'b0, den_ff});
   assign srem_sh = {srem_ff, rad_ff[obscs_pkg::RAD_W-1 -: 2]};
   assign trial   = (obscs_pkg::SREM_W+2)'({root_ff, 2'b01});
   assign take    = (srem_sh >= trial);
   assign root_in = take ? {root_ff[obscs_pkg::GAIN_W-2:0], 1'b1}
                         : {root_ff[obscs_pkg::GAIN_W-2:0], 1'b0};

   // output values
   always_comb begin
      if (ent_ff.zero_out) begin
         out_re_in = '0;
         out_im_in = '0;
      end else if (ent_ff.prev.hit) begin
         out_re_in = res_re_ff;
         out_im_in = obscs_pkg::scale_fin(mul_ff, old_im[SW-1]);
      end else begin
         out_re_in = old_re;
         out_im_in = old_im;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      band_in  = band_ff;
      q_pop    = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         obscs_pkg::B_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cnt_in   = '0;
               state_in = obscs_pkg::B_WORK;
            end
         end
         obscs_pkg::B_WORK: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == obscs_pkg::STEP_LAST) state_in = obscs_pkg::B_EMIT;
         end
         obscs_pkg::B_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               band_in  = '0;
               state_in = ent_ff.last ? obscs_pkg::B_GINIT : obscs_pkg::B_IDLE;
            end
         end
         obscs_pkg::B_GINIT: begin
            cnt_in   = '0;
            state_in = obscs_pkg::B_DIV;
         end
         obscs_pkg::B_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == obscs_pkg::CNT_W'(obscs_pkg::NUM_W - 1)) begin
               state_in = obscs_pkg::B_ROOTI;
            end
         end
         obscs_pkg::B_ROOTI: begin
            cnt_in   = '0;
            state_in = (|num_ff[obscs_pkg::NUM_W-1:obscs_pkg::RAD_W]) ? obscs_pkg::B_GNEXT
                                                                      : obscs_pkg::B_ROOT;
         end
         obscs_pkg::B_ROOT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == obscs_pkg::CNT_W'(obscs_pkg::GAIN_W - 1)) begin
               state_in = obscs_pkg::B_GNEXT;
            end
         end
         obscs_pkg::B_GNEXT: begin
            band_in  = band_ff + 1'b1;
            state_in = (band_ff == obscs_pkg::BAND_W'(obscs_pkg::MAX_BANDS - 1))
                       ? obscs_pkg::B_IDLE : obscs_pkg::B_GINIT;
         end
         default: state_in = obscs_pkg::B_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= obscs_pkg::B_IDLE;
         cnt_ff       <= '0;
         band_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         band_ff      <= band_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // bin store: read on pop, write back at the first work step
   always_ff @(posedge clock) begin
      if (q_pop) rd_ff <= store_mem[q_entry.idx];
      if ((state_ff == obscs_pkg::B_WORK) && (cnt_ff == '0)) begin
         store_mem[ent_ff.idx] <= ent_ff.store_filter ? {ent_ff.fre, ent_ff.fim}
                                                      : {ent_ff.sre, ent_ff.sim};
      end
   end

   // band energies and gains
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < obscs_pkg::MAX_BANDS; k++) begin
            fe_ff[k]   <= '0;
            se_ff[k]   <= '0;
            gain_ff[k] <= '0;
         end
      end else begin
         if ((state_ff == obscs_pkg::B_WORK) && ent_ff.cur.hit &&
             (cnt_ff != '0) && (cnt_ff < obscs_pkg::STEP_RE_FIN)) begin
            if (cnt_ff < obscs_pkg::CNT_W'(3)) begin
               fe_ff[e_idx] <= fe_rd + obscs_pkg::ENERGY_W'(sq_ff);
            end else begin
               se_ff[e_idx] <= se_rd + obscs_pkg::ENERGY_W'(sq_ff);
            end
         end
         if (state_ff == obscs_pkg::B_GNEXT) begin
            fe_ff[band_ff]   <= '0;
            se_ff[band_ff]   <= '0;
            gain_ff[band_ff] <= gnew_ff;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (q_pop) ent_ff <= q_entry;
      if (state_ff == obscs_pkg::B_WORK) begin
         sq_ff <= obscs_pkg::SQ_W'(sq_in);
         if (cnt_ff == '0) g_ff <= gain_ff[ent_ff.prev.idx];
         if (cnt_ff >= obscs_pkg::STEP_IM_MUL) mul_ff <= mul_op * g_ff;
         if (cnt_ff == obscs_pkg::STEP_RE_FIN) res_re_ff <= res_re_in;
      end
      if (load_out) begin
         out_re_ff    <= out_re_in;
         out_im_ff    <= out_im_in;
         frame_end_ff <= ent_ff.last;
      end
      if (state_ff == obscs_pkg::B_GINIT) begin
         den_ff <= obscs_pkg::DEN_W'(se_rd) + 1'b1;
         num_ff <= {fe_rd, {obscs_pkg::GAIN_W{1'b0}}};
         rem_ff <= '0;
      end
      if (state_ff == obscs_pkg::B_DIV) begin
         rem_ff <= qbit ? obscs_pkg::DEN_W'(rem_sh - {1'b0, den_ff})
                        : obscs_pkg::DEN_W'(rem_sh);
         num_ff <= {num_ff[obscs_pkg::NUM_W-2:0], qbit};
      end
      if (state_ff == obscs_pkg::B_ROOTI) begin
         rad_ff  <= num_ff[obscs_pkg::RAD_W-1:0];
         root_ff <= '0;
         srem_ff <= '0;
         gnew_ff <= '1;
      end
      if (state_ff == obscs_pkg::B_ROOT) begin
         srem_ff <= take ? obscs_pkg::SREM_W'(srem_sh - trial) : obscs_pkg::SREM_W'(srem_sh);
         root_ff <= root_in;
         rad_ff  <= rad_ff << 2;
         gnew_ff <= root_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_re    = out_re_ff;
   assign rsp_out_im    = out_im_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

FILE: rtl/octave_band_spectral_cross_synthesis.sv
// Top level of the octave band spectral cross synthesis block
//
// Request channel (req_*): one complex bin pair of source and filter spectrum
// per request, bins 0..FRAME_BINS-1 in order. Response channel (rsp_*): the
// same bin of the previous frame, scaled by its octave band gain and
// saturated; rsp_frame_end marks the last bin. Both use valid/ready.
// Registers on csr_* (pass-through, sibilance bin, low cut) are sampled at bin 0.
// The back end works one bin at a time (store read/write, four squares, two
// gain multiplies, emit) before it takes the next; a four-entry queue lets the
// front keep accepting meanwhile. After the last bin of a frame the back end
// computes ten band gains, each a restoring divide and a square root, while
// the queue fills and then holds off requests.
// Bins outside every band pass unscaled; bins at or below the low cut respond zero.
// Reset clears counters, energies and gains; the first frame responds zeros.
// A stalled receiver holds the response register; the back end then waits
// and the queue back-pressures req_ready.
module octave_band_spectral_cross_synthesis (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [obscs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [obscs_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [obscs_pkg::SAMPLE_WIDTH-1:0] req_source_re,
   input  logic signed [obscs_pkg::SAMPLE_WIDTH-1:0] req_source_im,
   input  logic signed [obscs_pkg::SAMPLE_WIDTH-1:0] req_filter_re,
   input  logic signed [obscs_pkg::SAMPLE_WIDTH-1:0] req_filter_im,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [obscs_pkg::SAMPLE_WIDTH-1:0] rsp_out_re,
   output logic signed [obscs_pkg::SAMPLE_WIDTH-1:0] rsp_out_im,
   output logic                                    rsp_frame_end
);

   logic                 q_full, q_push, q_valid, q_pop;
   obscs_pkg::entry_type q_wdata, q_rdata;

   obscs_front u_front (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_valid, .req_ready, .req_source_re, .req_source_im,
      .req_filter_re, .req_filter_im,
      .q_full, .q_push, .q_entry(q_wdata)
   );

   obscs_fifo u_fifo (
      .clock, .reset,
      .push(q_push), .push_data(q_wdata), .full(q_full),
      .pop(q_pop), .valid(q_valid), .pop_data(q_rdata)
   );

   obscs_back u_back (
      .clock, .reset,
      .q_valid, .q_entry(q_rdata), .q_pop,
      .rsp_valid, .rsp_ready, .rsp_out_re, .rsp_out_im, .rsp_frame_end
   );

endmodule

FILE: rtl/obscs_checker.sv
// Port-level checker of the octave band cross synthesis block and its bind
`include "octave_band_spectral_cross_synthesis_assert.svh"

module obscs_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [obscs_pkg::SAMPLE_WIDTH-1:0] rsp_out_re,
   input logic signed [obscs_pkg::SAMPLE_WIDTH-1:0] rsp_out_im,
   input logic                                    rsp_frame_end
);

   // a stalled response holds
   `OBSCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_re) && $stable(rsp_out_im) && $stable(rsp_frame_end))

   // gain computation follows the last bin, so no response right after it
   `OBSCS_ASSERT_NEXT(a_gain_pause, clock, reset, rsp_valid && rsp_ready && rsp_frame_end, !rsp_valid)

   // reset empties the response register
   `OBSCS_ASSERT_RESET(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind octave_band_spectral_cross_synthesis obscs_checker u_obscs_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_out_re(rsp_out_re), .rsp_out_im(rsp_out_im), .rsp_frame_end(rsp_frame_end)
);

FILE: verif/tb.sv
// Self-checking testbench of the octave band spectral cross synthesis block
module tb;

   localparam int SW = obscs_pkg::SAMPLE_WIDTH;
   localparam int FB = obscs_pkg::FRAME_BINS;
   localparam int MB = obscs_pkg::MAX_BANDS;

   localparam int STALL_LIMIT = 20000;   // cycles with no request or response accepted
   localparam int SETTLE      = 1200;    // back end gain pass after a frame, with margin

   // one predicted response
   typedef struct {
      logic signed [SW-1:0] re;
      logic signed [SW-1:0] im;
      logic                 last;
   } vocoded_bin_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [obscs_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [obscs_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SW-1:0] req_source_re = '0;
   logic signed [SW-1:0] req_source_im = '0;
   logic signed [SW-1:0] req_filter_re = '0;
   logic signed [SW-1:0] req_filter_im = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SW-1:0] rsp_out_re;
   logic signed [SW-1:0] rsp_out_im;
   logic rsp_frame_end;

   octave_band_spectral_cross_synthesis dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   obscs_pkg::cfg_type csr_shadow = '{pass: 1'b0, sib: obscs_pkg::SIB_BIN_RESET, cut: '0};
   obscs_pkg::cfg_type frame_cfg  = '{pass: 1'b0, sib: obscs_pkg::SIB_BIN_RESET, cut: '0};
   obscs_pkg::cfg_type held_cfg   = '{pass: 1'b0, sib: obscs_pkg::SIB_BIN_RESET, cut: '0};
   int               held_re [FB];
   int               held_im [FB];
   logic [23:0]      gains [MB];
   longint unsigned  filt_pow [MB];
   longint unsigned  src_pow [MB];
   int               next_bin = 0;
   vocoded_bin_type  pending_bins [$];

   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int quiet_cycles = 0;
   int sent_count = 0;

   initial begin
      for (int i = 0; i < FB; i++) begin
         held_re[i] = 0;
         held_im[i] = 0;
      end
      for (int k = 0; k < MB; k++) begin
         gains[k] = '0;
         filt_pow[k] = 0;
         src_pow[k] = 0;
      end
   end

   function automatic int band_top(obscs_pkg::cfg_type c);
      if (c.pass && c.sib < FB) return int'(c.sib);
      return FB;
   endfunction

   // octave band holding bin i, -1 when outside every band
   function automatic int octave_of(int i, obscs_pkg::cfg_type c);
      int hi;
      int lo;
      hi = band_top(c);
      for (int k = 0; k < MB; k++) begin
         lo = hi / 2;
         if (lo <= int'(c.cut)) return -1;
         if (i >= lo && i < hi) return k;
         hi = lo;
      end
      return -1;
   endfunction

   function automatic longint unsigned int_root(longint unsigned x);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // sqrt(F/(S+1)) in Q12.12
   function automatic logic [23:0] band_gain_of(longint unsigned f, longint unsigned s);
      longint unsigned d;
      longint unsigned q;
      longint unsigned r;
      d = s + 1;
      q = f / d;
      r = f % d;
      if (q >= (64'd1 << 24)) return 24'hFFFFFF;
      for (int n = 0; n < 24; n++) begin
         r = r << 1;
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q = q | 64'd1;
         end
      end
      return 24'(int_root(q));
   endfunction

   // gain applied with round half away from zero, then saturation
   function automatic logic signed [SW-1:0] apply_gain(int x, logic [23:0] g);
      longint unsigned mag;
      longint v;
      mag = longint'(x < 0 ? -x : x) * longint'(g);
      mag = (mag + 2048) >> 12;
      v = (x < 0) ? -longint'(mag) : longint'(mag);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[SW-1:0];
   endfunction

   // work out the response to one accepted request and advance the state
   task automatic vocode_bin(int sre, int sim, int fre, int fim);
      vocoded_bin_type o;
      int k;
      o.last = (next_bin == FB - 1);
      if (next_bin <= int'(held_cfg.cut)) begin
         o.re = '0;
         o.im = '0;
      end else begin
         k = octave_of(next_bin, held_cfg);
         if (k >= 0) begin
            o.re = apply_gain(held_re[next_bin], gains[k]);
            o.im = apply_gain(held_im[next_bin], gains[k]);
         end else begin
            o.re = held_re[next_bin][SW-1:0];
            o.im = held_im[next_bin][SW-1:0];
         end
      end
      pending_bins.push_back(o);

      if (next_bin == 0) frame_cfg = csr_shadow;
      if (frame_cfg.pass && next_bin >= band_top(frame_cfg)) begin
         held_re[next_bin] = fre;
         held_im[next_bin] = fim;
      end else begin
         held_re[next_bin] = sre;
         held_im[next_bin] = sim;
      end
      k = octave_of(next_bin, frame_cfg);
      if (k >= 0) begin
         filt_pow[k] += longint'(fre * fre) + longint'(fim * fim);
         src_pow[k]  += longint'(sre * sre) + longint'(sim * sim);
      end
      if (next_bin == FB - 1) begin
         for (int b = 0; b < MB; b++) begin
            gains[b] = band_gain_of(filt_pow[b], src_pow[b]);
            filt_pow[b] = 0;
            src_pow[b] = 0;
         end
         held_cfg = frame_cfg;
         next_bin = 0;
      end else begin
         next_bin++;
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("tb: %s mismatch: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   // response checking, receiver stalls and watchdog
   always @(posedge clock) begin
      vocoded_bin_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_bins.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               e = pending_bins.pop_front();
               if (rsp_out_re !== e.re) report_mismatch("out_re", rsp_out_re, e.re);
               if (rsp_out_im !== e.im) report_mismatch("out_im", rsp_out_im, e.im);
               if (rsp_frame_end !== e.last) report_mismatch("frame_end", rsp_frame_end, e.last);
            end
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // one request on the req channel, with a random gap first
   task automatic send_bin(int sre, int sim, int fre, int fim);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_source_re <= sre[SW-1:0];
      req_source_im <= sim[SW-1:0];
      req_filter_re <= fre[SW-1:0];
      req_filter_im <= fim[SW-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      vocode_bin(sre, sim, fre, fim);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_bins.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // one register write; the caller drops the write enable afterwards
   task automatic write_reg(logic [obscs_pkg::CSR_IDX_W-1:0] idx, int val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[obscs_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      if (idx == obscs_pkg::REG_SIB_PASS) csr_shadow.pass = val[0];
      else if (idx == obscs_pkg::REG_SIB_BIN) csr_shadow.sib = val[obscs_pkg::SIB_W-1:0];
      else if (idx == obscs_pkg::REG_LOW_CUT) csr_shadow.cut = val[obscs_pkg::CUT_W-1:0];
   endtask

   task automatic set_regs(int pass, int sib, int cut);
      drain();
      write_reg(obscs_pkg::REG_SIB_PASS, pass);
      write_reg(obscs_pkg::REG_SIB_BIN, sib);
      write_reg(obscs_pkg::REG_LOW_CUT, cut);
      csr_we <= 1'b0;
   endtask

   function automatic int any_sample();
      int v;
      v = $urandom();
      return int'($signed(v[15:0]));
   endfunction

   function automatic int edge_sample();
      case ($urandom_range(0, 3))
         0: return -32768;
         1: return 32767;
         2: return -1;
         default: return 0;
      endcase
   endfunction

   // random bins of mixed character; idling pattern rotates every 40 sent
   task automatic random_bins(int count);
      int s0, s1, f0, f1;
      for (int n = 0; n < count; n++) begin
         case ((sent_count / 40) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         case ($urandom_range(0, 9))
            4, 5, 6: begin
               s0 = $urandom_range(0, 600) - 300; s1 = $urandom_range(0, 600) - 300;
               f0 = any_sample(); f1 = any_sample();
            end
            7: begin
               s0 = any_sample(); s1 = any_sample(); f0 = 0; f1 = 0;
            end
            8: begin
               s0 = edge_sample(); s1 = edge_sample(); f0 = edge_sample(); f1 = edge_sample();
            end
            9: begin
               s0 = any_sample(); s1 = any_sample();
               f0 = $urandom_range(0, 200) - 100; f1 = $urandom_range(0, 200) - 100;
            end
            default: begin
               s0 = any_sample(); s1 = any_sample(); f0 = any_sample(); f1 = any_sample();
            end
         endcase
         send_bin(s0, s1, f0, f1);
         sent_count++;
      end
   endtask

   // field extremes straight after reset; first frame responds zeros
   task automatic test_field_extremes;
      int vals[4] = '{-32768, 32767, 0, -1};
      for (int n = 0; n < 24; n++)
         send_bin(vals[n % 4], vals[(n / 4) % 4], vals[(n + 1) % 4], vals[(n / 2) % 4]);
   endtask

   // default bands, with a pause until every response is back
   task automatic test_default_bands;
      set_regs(0, 93, 0);
      random_bins(60);
      req_valid <= 1'b0;
      while (pending_bins.size() != 0) @(posedge clock);
      random_bins(60);
   endtask

   task automatic test_passthrough_high;
      set_regs(1, 93, 3);
      random_bins(90);
   endtask

   // sibilance bin zero: no bands, filter passes everywhere
   task automatic test_passthrough_zero;
      set_regs(1, 0, 0);
      random_bins(90);
   endtask

   // sibilance bin past the frame: clamped top, no pass-through
   task automatic test_sibilance_clamp;
      set_regs(1, 1023, 40);
      random_bins(70);
      set_regs(1, 512, 0);
      random_bins(60);
   endtask

   // cutoff at its extreme zeroes every bin; then a sibilance bin at the bottom, then a cutoff of one
   task automatic test_cutoff_extremes;
      set_regs(0, 1, 511);
      random_bins(70);
      set_regs(1, 1, 255);
      random_bins(60);
      set_regs(0, 512, 1);
      random_bins(66);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_default_bands();
      test_passthrough_high();
      test_passthrough_zero();
      test_sibilance_clamp();
      test_cutoff_extremes();
      drain();
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: octave_band_spectral_cross_synthesis.f
+incdir+rtl
rtl/obscs_pkg.sv
rtl/obscs_front.sv
rtl/obscs_fifo.sv
rtl/obscs_back.sv
rtl/octave_band_spectral_cross_synthesis.sv
rtl/obscs_checker.sv
verif/tb.sv
